FILE: rtl/rect_difference_fragments_assert.svh
// assertion macros shared by the rectangle difference block
`ifndef RECT_DIFFERENCE_FRAGMENTS_ASSERT_SVH
`define RECT_DIFFERENCE_FRAGMENTS_ASSERT_SVH

// same-cycle implication, checked on the rising clock, off during reset
`define RDF_ASSERT_IMPLY(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock, off during reset
`define RDF_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: rtl/rdf_pkg.sv
package rdf_pkg;

   localparam int CoordW  = 16;
   localparam int SizeW   = 15;
   localparam int ExtW    = CoordW + 1;
   localparam int KindW   = 3;
   localparam int NumFrag = 4;
   localparam int SelW    = $clog2(NumFrag);

   typedef logic [KindW-1:0] kind_type;

   // fragment kinds
   localparam kind_type KIND_WHOLE  = 3'd0;
   localparam kind_type KIND_BOTTOM = 3'd1;
   localparam kind_type KIND_LEFT   = 3'd2;
   localparam kind_type KIND_RIGHT  = 3'd3;
   localparam kind_type KIND_TOP    = 3'd4;

   // one input transaction: base rectangle and remove rectangle
   typedef struct packed {
      logic signed [CoordW-1:0] bx;
      logic signed [CoordW-1:0] by;
      logic [SizeW-1:0]         bw;
      logic [SizeW-1:0]         bh;
      logic signed [CoordW-1:0] cx;
      logic signed [CoordW-1:0] cy;
      logic [SizeW-1:0]         cw;
      logic [SizeW-1:0]         ch;
   } rect_pair_type;

   // one output fragment
   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic [SizeW-1:0]         w;
      logic [SizeW-1:0]         h;
      kind_type                 kind;
   } frag_type;

   // all fragments of one input, slot order is emit order
   typedef struct packed {
      frag_type [NumFrag-1:0] slot;
      logic [NumFrag-1:0]     mask;
   } frag_set_type;

   // emitter status toward the input stage
   typedef struct packed {
      logic free;
      logic load;
      logic pending;
   } emit_status_type;

endpackage

FILE: rtl/rect_difference_fragments.sv
// channel   direction  transaction
// req_      in         base and remove rectangle, one per transaction
// rsp_      out        one fragment per transaction, last flag on the final one
//
// an input transaction yields 0 to 4 fragments and holds the fragment
// buffer until its last fragment is loaded into the output register; the
// output register sets the rate, one fragment per cycle while rsp_ready holds
// first fragment passes the input register, fragment buffer and output register
// synchronous active-high reset empties the input stage, buffer and output
// a stalled output holds the buffer, which then back-pressures req_ready
module rect_difference_fragments
   import rdf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CoordW-1:0] req_base_x,
   input  logic signed [CoordW-1:0] req_base_y,
   input  logic [SizeW-1:0]         req_base_w,
   input  logic [SizeW-1:0]         req_base_h,
   input  logic signed [CoordW-1:0] req_cut_x,
   input  logic signed [CoordW-1:0] req_cut_y,
   input  logic [SizeW-1:0]         req_cut_w,
   input  logic [SizeW-1:0]         req_cut_h,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [CoordW-1:0] rsp_frag_x,
   output logic signed [CoordW-1:0] rsp_frag_y,
   output logic [SizeW-1:0]         rsp_frag_w,
   output logic [SizeW-1:0]         rsp_frag_h,
   output logic [KindW-1:0]         rsp_frag_kind,
   output logic                     rsp_frag_last
);

`include "rect_difference_fragments_assert.svh"

   logic            in_vld_ff, in_vld_in;
   rect_pair_type   in_data_ff, in_data_in;
   logic            in_take;
   frag_set_type    frags;
   emit_status_type status;

   // input register, moves on when the buffer frees up
   assign in_take   = in_vld_ff && status.free;
   assign req_ready = !in_vld_ff || status.free;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      if (req_valid && req_ready) begin
         in_vld_in     = 1'b1;
         in_data_in.bx = req_base_x;
         in_data_in.by = req_base_y;
         in_data_in.bw = req_base_w;
         in_data_in.bh = req_base_h;
         in_data_in.cx = req_cut_x;
         in_data_in.cy = req_cut_y;
         in_data_in.cw = req_cut_w;
         in_data_in.ch = req_cut_h;
      end else if (in_take) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_data_ff <= in_data_in;
   end

   // clip and split
   rdf_clip u_clip (
      .pair  (in_data_ff),
      .frags (frags)
   );

   // fragment buffer and output register
   rdf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load_en       (in_take),
      .load_set      (frags),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_frag_x    (rsp_frag_x),
      .rsp_frag_y    (rsp_frag_y),
      .rsp_frag_w    (rsp_frag_w),
      .rsp_frag_h    (rsp_frag_h),
      .rsp_frag_kind (rsp_frag_kind),
      .rsp_frag_last (rsp_frag_last)
   );

   // checks
   `RDF_ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && !status.free,
      in_vld_ff, "input stage dropped a transaction")
   `RDF_ASSERT_NEXT(a_buf_hold, clock, reset, status.pending && !status.load,
      status.pending, "fragment buffer lost pending fragments")
   `RDF_ASSERT_IMPLY(a_whole_last, clock, reset, rsp_valid && rsp_frag_kind == KIND_WHOLE,
      rsp_frag_last, "whole-base fragment not marked last")

endmodule

FILE: rtl/rdf_clip.sv
module rdf_clip
   import rdf_pkg::*;
(
   input  rect_pair_type pair,
   output frag_set_type  frags
);

   logic signed [ExtW-1:0] bx, by, bw, bh, cx, cy, cw, ch;
   logic signed [ExtW-1:0] bex, bey, cex, cey;
   logic signed [ExtW-1:0] rx, ry, rex, rey, rw, rh;
   logic                   disjoint, equal_base, zero_area;

   // widen everything by one bit so extents never wrap
   assign bx = ExtW'(pair.bx);
   assign by = ExtW'(pair.by);
   assign cx = ExtW'(pair.cx);
   assign cy = ExtW'(pair.cy);
   assign bw = signed'(ExtW'(pair.bw));
   assign bh = signed'(ExtW'(pair.bh));
   assign cw = signed'(ExtW'(pair.cw));
   assign ch = signed'(ExtW'(pair.ch));

   assign bex = bx + bw;
   assign bey = by + bh;
   assign cex = cx + cw;
   assign cey = cy + ch;

   // clip the remove rectangle to the base
   assign disjoint = (cx >= bex) || (cex <= bx) || (cy >= bey) || (cey <= by);
   assign rx  = (cx < bx) ? bx : cx;
   assign ry  = (cy < by) ? by : cy;
   assign rex = (cex > bex) ? bex : cex;
   assign rey = (cey > bey) ? bey : cey;
   assign rw  = rex - rx;
   assign rh  = rey - ry;

   // a disjoint cut collapses to the all-zero rectangle
   assign equal_base = disjoint ?
      (pair.bx == '0 && pair.by == '0 && pair.bw == '0 && pair.bh == '0) :
      (rx == bx && ry == by && rw == bw && rh == bh);
   assign zero_area = disjoint || (rw == '0 && rh == '0);

   // build fragments in emit order: bottom, left, right, top
   always_comb begin
      frags.mask = '0;
      frags.slot = '0;
      if (equal_base) begin
         frags.mask = '0;
      end else if (zero_area) begin
         frags.mask[0]      = 1'b1;
         frags.slot[0].x    = pair.bx;
         frags.slot[0].y    = pair.by;
         frags.slot[0].w    = pair.bw;
         frags.slot[0].h    = pair.bh;
         frags.slot[0].kind = KIND_WHOLE;
      end else begin
         frags.mask[0]      = by < ry;
         frags.slot[0].x    = pair.bx;
         frags.slot[0].y    = pair.by;
         frags.slot[0].w    = pair.bw;
         frags.slot[0].h    = SizeW'(ry - by);
         frags.slot[0].kind = KIND_BOTTOM;

         frags.mask[1]      = bx < rx;
         frags.slot[1].x    = pair.bx;
         frags.slot[1].y    = ry[CoordW-1:0];
         frags.slot[1].w    = SizeW'(rx - bx);
         frags.slot[1].h    = rh[SizeW-1:0];
         frags.slot[1].kind = KIND_LEFT;

         frags.mask[2]      = bex > rex;
         frags.slot[2].x    = rex[CoordW-1:0];
         frags.slot[2].y    = ry[CoordW-1:0];
         frags.slot[2].w    = SizeW'(bex - rex);
         frags.slot[2].h    = rh[SizeW-1:0];
         frags.slot[2].kind = KIND_RIGHT;

         frags.mask[3]      = bey > rey;
         frags.slot[3].x    = pair.bx;
         frags.slot[3].y    = rey[CoordW-1:0];
         frags.slot[3].w    = pair.bw;
         frags.slot[3].h    = SizeW'(bey - rey);
         frags.slot[3].kind = KIND_TOP;
      end
   end

endmodule

FILE: rtl/rdf_emit.sv
module rdf_emit
   import rdf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_en,
   input  frag_set_type             load_set,
   output emit_status_type          status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [CoordW-1:0] rsp_frag_x,
   output logic signed [CoordW-1:0] rsp_frag_y,
   output logic [SizeW-1:0]         rsp_frag_w,
   output logic [SizeW-1:0]         rsp_frag_h,
   output logic [KindW-1:0]         rsp_frag_kind,
   output logic                     rsp_frag_last
);

   frag_type [NumFrag-1:0] slot_ff, slot_in;
   logic [NumFrag-1:0]     mask_ff, mask_in, rest_mask;
   logic [SelW-1:0]        sel;
   logic                   out_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   frag_type               frag_ff, frag_in;
   logic                   last_ff, last_in;

   // lowest pending slot goes out first
   always_comb begin
      sel = '0;
      for (int i = NumFrag - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SelW'(i);
         end
      end
   end

   assign rest_mask = mask_ff & (mask_ff - 1'b1);
   assign out_load  = (mask_ff != '0) && (!rsp_valid_ff || rsp_ready);

   assign status.pending = mask_ff != '0;
   assign status.load    = out_load;
   assign status.free    = (mask_ff == '0) || (out_load && rest_mask == '0);

   // fragment buffer
   always_comb begin
      mask_in = mask_ff;
      slot_in = slot_ff;
      if (load_en) begin
         mask_in = load_set.mask;
         slot_in = load_set.slot;
      end else if (out_load) begin
         mask_in = rest_mask;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      frag_in      = frag_ff;
      last_in      = last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         frag_in      = slot_ff[sel];
         last_in      = rest_mask == '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff <= slot_in;
      frag_ff <= frag_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frag_x    = frag_ff.x;
   assign rsp_frag_y    = frag_ff.y;
   assign rsp_frag_w    = frag_ff.w;
   assign rsp_frag_h    = frag_ff.h;
   assign rsp_frag_kind = frag_ff.kind;
   assign rsp_frag_last = last_ff;

endmodule
